>>> sv/hxpid_pkg.sv
// ---------------------------------------------------------------------------
// hxpid_pkg: shared types, constants and fixed-point helpers
// Holds register codes, filter and mixer coefficients and the rounding and
// saturation functions of the hexacopter attitude PID and motor mixer.
// ---------------------------------------------------------------------------
package hxpid_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_PITCH_P = 3'd0,
    REG_PITCH_D = 3'd1,
    REG_PITCH_I = 3'd2,
    REG_ROLL_P  = 3'd3,
    REG_ROLL_D  = 3'd4,
    REG_ROLL_I  = 3'd5,
    REG_BASE_THR = 3'd6
  } reg_idx_e;

  localparam int MotorMinDefault = 1235;
  localparam int MotorMaxDefault = 1500;

  localparam int GainW = 24;
  localparam int ThrW  = 11;
  localparam int SmpW  = 16;
  localparam int RefW  = 12;
  localparam int FltW  = 24;
  localparam int IntW  = 32;
  localparam int AccW  = 64;
  localparam int MulW  = 33;
  localparam int TermW = 44;
  localparam int MotW  = 11;

  // Reset values of the registers
  localparam logic [GainW-1:0] PitchPRst = 24'd204800;
  localparam logic [GainW-1:0] PitchDRst = 24'd1638400;
  localparam logic [GainW-1:0] PitchIRst = 24'd410;
  localparam logic [GainW-1:0] RollPRst  = 24'd204800;
  localparam logic [GainW-1:0] RollDRst  = 24'd1228800;
  localparam logic [GainW-1:0] RollIRst  = 24'd410;
  localparam logic [ThrW-1:0]  BaseThrRst = 11'd1280;

  // Q0.16 filter coefficients; sample terms carry the extra factor 256
  localparam logic [MulW-1:0] CoefFilt    = 33'd59297;
  localparam logic [MulW-1:0] CoefSmp     = 33'd1596416;   // 6236 * 256
  localparam logic [MulW-1:0] CoefRateF   = 33'd166;
  localparam logic [MulW-1:0] CoefRateSmp = 33'd16735232;  // 65372 * 256
  localparam logic [MulW-1:0] CoefCos30   = 33'd56754;

  // Round half up by 16 bits, then saturate to 24 bits signed
  function automatic logic signed [FltW-1:0] rnd16_sat24(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] r;
    r = (x + 64'sd32768) >>> 16;
    if (r > 64'sd8388607) return 24'sh7FFFFF;
    if (r < -64'sd8388608) return 24'sh800000;
    return r[FltW-1:0];
  endfunction

  // Round half up by 14 bits
  function automatic logic signed [TermW-1:0] rnd14(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] r;
    r = (x + 64'sd8192) >>> 14;
    return r[TermW-1:0];
  endfunction

  // Saturate a 33-bit sum to 32 bits signed
  function automatic logic signed [IntW-1:0] sat32(input logic signed [IntW:0] x);
    if (x > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -33'sh0_8000_0000) return 32'sh8000_0000;
    return x[IntW-1:0];
  endfunction

  // Saturate a 25-bit difference to 24 bits signed
  function automatic logic signed [FltW-1:0] sat24(input logic signed [FltW:0] x);
    if (x > 25'sh07F_FFFF) return 24'sh7FFFFF;
    if (x < -25'sh080_0000) return 24'sh800000;
    return x[FltW-1:0];
  endfunction

endpackage

>>> sv/hexacopter_attitude_pid_mixer_core.sv
// ---------------------------------------------------------------------------
// hexacopter_attitude_pid_mixer_core: roll/pitch PID with six-motor mixer
// One sensor tick in, six motor commands out, computed on one shared
// multiply-accumulate unit under a step sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one sensor tick: tuser is the armed flag, tdata the
//   accelerometer, gyro and reference samples. m_axis returns one result per
//   tick with the six motor commands. Gains and base throttle are written on
//   the cfg port while the block is idle.
// Flow:
//   A disarmed tick goes from the idle state straight to the done state and
//   loads the output register there. An armed tick runs 22 sequencer steps
//   on the shared 33x33 multiplier and adder, then clamps and loads the
//   output in the done state. s_axis_tready is high only in the idle state,
//   so a new tick is taken only after the last one's result is loaded.
// Reset:
//   Gains and base throttle take their reset values, filter, error and
//   integrator state clears, no result is pending.
// Stall:
//   A result waits in the output register; a finished tick holds in the done
//   state until the register frees, and no new tick is taken meanwhile.
// ---------------------------------------------------------------------------
module hexacopter_attitude_pid_mixer_core
  import hxpid_pkg::*;
#(
  parameter int MOTOR_MIN = MotorMinDefault,
  parameter int MOTOR_MAX = MotorMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_pitch[15:0] accel_roll[31:16] gyro_pitch[47:32] gyro_roll[63:48]
  // pitch_ref[75:64] roll_ref[87:76]
  input  logic [87:0] s_axis_tdata,
  // armed[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // motor_one[10:0] motor_two[21:11] motor_three[32:22] motor_four[43:33]
  // motor_five[54:44] motor_six[65:55], zero fill [71:66]
  output logic [71:0] m_axis_tdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_e;
  typedef enum logic [1:0] {OP_CLR, OP_ADD, OP_SUB, OP_SHADD} mac_op_e;

  localparam int StepW = 5;
  localparam logic [StepW-1:0] LastStep = 5'd21;
  localparam logic signed [AccW-1:0] HiQ32 = {32'(MOTOR_MAX), 32'd0};
  localparam logic signed [AccW-1:0] LoQ32 = {32'(MOTOR_MIN), 32'd0};

  state_e            state_q;
  logic [StepW-1:0]  step_q;
  logic              armed_q;

  // Configuration registers
  logic [GainW-1:0] pitch_p_q, pitch_d_q, pitch_i_q, roll_p_q, roll_d_q, roll_i_q;
  logic [ThrW-1:0]  base_thr_q;

  // Latched tick samples
  logic signed [SmpW-1:0] accel_pitch_q, accel_roll_q, gyro_pitch_q, gyro_roll_q;
  logic signed [RefW-1:0] pitch_ref_q, roll_ref_q;

  // Controller state
  logic signed [SmpW-1:0] prev_pitch_q, prev_roll_q, prev_rate_q;
  logic signed [FltW-1:0] pitch_flt_q, roll_flt_q, rate_flt_q;
  logic signed [FltW-1:0] pitch_err_q, roll_err_q;
  logic signed [IntW-1:0] pitch_int_q, roll_int_q;

  // Datapath registers
  logic signed [AccW-1:0]  acc_q;
  logic signed [TermW-1:0] r16_q;
  logic [31:0]             p16_lo_q;
  logic signed [AccW-1:0]  v_q [6];

  logic [71:0] out_data_q;
  logic        out_valid_q;
  logic        out_load;

  // Shared multiplier operands
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [2*MulW-1:0] prod;
  logic signed [AccW-1:0]   prod_w, acc_d;
  logic signed [TermW-1:0]  p16;
  mac_op_e                  op;

  assign p16 = rnd14(acc_q);

  // Select operands and accumulate mode for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    op    = OP_ADD;
    case (step_q)
      5'd0:  begin mul_a = CoefFilt;    mul_b = MulW'(pitch_flt_q); op = OP_CLR; end
      5'd1:  begin mul_a = CoefSmp;     mul_b = MulW'(prev_pitch_q); end
      5'd2:  begin mul_a = CoefFilt;    mul_b = MulW'(roll_flt_q);  op = OP_CLR; end
      5'd3:  begin mul_a = CoefSmp;     mul_b = MulW'(prev_roll_q); end
      5'd4:  begin mul_a = CoefRateF;   mul_b = MulW'(rate_flt_q);  op = OP_CLR; end
      5'd5:  begin mul_a = CoefRateSmp; mul_b = MulW'(prev_rate_q); end
      5'd7:  begin mul_a = MulW'(roll_p_q);  mul_b = MulW'(roll_err_q); op = OP_CLR; end
      5'd8:  begin mul_a = MulW'(roll_d_q);  mul_b = MulW'(rate_flt_q); op = OP_SUB; end
      5'd9:  begin mul_a = MulW'(roll_i_q);  mul_b = MulW'(roll_int_q); end
      5'd10: begin mul_a = MulW'(pitch_p_q); mul_b = MulW'(pitch_err_q); op = OP_CLR; end
      5'd11: begin
        mul_a = MulW'(pitch_d_q);
        mul_b = MulW'(signed'({gyro_pitch_q, 8'd0}));
      end
      5'd12: begin mul_a = MulW'(pitch_i_q); mul_b = MulW'(pitch_int_q); end
      5'd13: begin mul_a = CoefCos30; mul_b = MulW'(p16 >>> 32); op = OP_CLR; end
      5'd14: begin mul_a = CoefCos30; mul_b = {1'b0, p16_lo_q}; op = OP_SHADD; end
      default: begin mul_a = '0; mul_b = '0; op = OP_ADD; end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_w = prod[AccW-1:0];

  always_comb begin
    case (op)
      OP_CLR:   acc_d = prod_w;
      OP_ADD:   acc_d = acc_q + prod_w;
      OP_SUB:   acc_d = acc_q - prod_w;
      OP_SHADD: acc_d = (acc_q <<< 32) + prod_w;
      default:  acc_d = acc_q;
    endcase
  end

  // Clamp, round and cap one motor lane
  function automatic logic [MotW-1:0] motor_out(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] x;
    logic [11:0]            c;
    x = (v < LoQ32) ? LoQ32 : ((v > HiQ32) ? HiQ32 : v);
    x = x + 64'sh8000_0000;
    c = x[43:32];
    return (c > 12'd2047) ? 11'd2047 : c[MotW-1:0];
  endfunction

  logic [71:0] mix_data;
  assign mix_data = {6'd0, motor_out(v_q[5]), motor_out(v_q[4]), motor_out(v_q[3]),
                     motor_out(v_q[2]), motor_out(v_q[1]), motor_out(v_q[0])};

  // Mixer terms for step fifteen
  logic signed [AccW-1:0] thr_q32, r_full, r_half;
  assign thr_q32 = {21'd0, base_thr_q, 32'd0};
  assign r_full  = AccW'(r16_q) <<< 16;
  assign r_half  = AccW'(r16_q) <<< 15;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Load the output register once it is free
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_p_q  <= PitchPRst;
      pitch_d_q  <= PitchDRst;
      pitch_i_q  <= PitchIRst;
      roll_p_q   <= RollPRst;
      roll_d_q   <= RollDRst;
      roll_i_q   <= RollIRst;
      base_thr_q <= BaseThrRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_PITCH_P:  pitch_p_q  <= cfg_wdata_i;
        REG_PITCH_D:  pitch_d_q  <= cfg_wdata_i;
        REG_PITCH_I:  pitch_i_q  <= cfg_wdata_i;
        REG_ROLL_P:   roll_p_q   <= cfg_wdata_i;
        REG_ROLL_D:   roll_d_q   <= cfg_wdata_i;
        REG_ROLL_I:   roll_i_q   <= cfg_wdata_i;
        REG_BASE_THR: base_thr_q <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      armed_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      prev_pitch_q <= '0;
      prev_roll_q  <= '0;
      prev_rate_q  <= '0;
      pitch_flt_q  <= '0;
      roll_flt_q   <= '0;
      rate_flt_q   <= '0;
      pitch_err_q  <= '0;
      roll_err_q   <= '0;
      pitch_int_q  <= '0;
      roll_int_q   <= '0;
    end else begin
      // Raise valid on a load, drop it once the result transfers
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (s_axis_tvalid) begin
            armed_q       <= s_axis_tuser;
            accel_pitch_q <= s_axis_tdata[15:0];
            accel_roll_q  <= s_axis_tdata[31:16];
            gyro_pitch_q  <= s_axis_tdata[47:32];
            gyro_roll_q   <= s_axis_tdata[63:48];
            pitch_ref_q   <= s_axis_tdata[75:64];
            roll_ref_q    <= s_axis_tdata[87:76];
            state_q       <= s_axis_tuser ? ST_RUN : ST_DONE;
          end
        end
        ST_RUN: begin
          acc_q <= acc_d;
          case (step_q)
            5'd2: begin
              pitch_flt_q  <= rnd16_sat24(acc_q);
              prev_pitch_q <= accel_pitch_q;
            end
            5'd4: begin
              roll_flt_q  <= rnd16_sat24(acc_q);
              prev_roll_q <= accel_roll_q;
            end
            5'd6: begin
              rate_flt_q  <= rnd16_sat24(acc_q);
              prev_rate_q <= gyro_roll_q;
              pitch_int_q <= sat32(33'(pitch_int_q) + 33'(pitch_err_q));
              roll_int_q  <= sat32(33'(roll_int_q) + 33'(roll_err_q));
              pitch_err_q <= sat24(25'(signed'({pitch_ref_q, 8'd0})) - 25'(pitch_flt_q));
              roll_err_q  <= sat24(25'(signed'({roll_ref_q, 8'd0})) - 25'(roll_flt_q));
            end
            5'd10: r16_q    <= p16;
            5'd13: p16_lo_q <= p16[31:0];
            5'd15: begin
              v_q[0] <= thr_q32 + r_full;
              v_q[1] <= thr_q32 - r_full;
              v_q[2] <= thr_q32 - r_half - acc_q;
              v_q[3] <= thr_q32 + r_half + acc_q;
              v_q[4] <= thr_q32 + r_half - acc_q;
              v_q[5] <= thr_q32 - r_half + acc_q;
            end
            // Move each motor's excess onto its opposite, in motor order
            5'd16: if (v_q[0] > HiQ32) begin
              v_q[1] <= v_q[1] - (v_q[0] - HiQ32); v_q[0] <= HiQ32;
            end
            5'd17: if (v_q[1] > HiQ32) begin
              v_q[0] <= v_q[0] - (v_q[1] - HiQ32); v_q[1] <= HiQ32;
            end
            5'd18: if (v_q[2] > HiQ32) begin
              v_q[3] <= v_q[3] - (v_q[2] - HiQ32); v_q[2] <= HiQ32;
            end
            5'd19: if (v_q[3] > HiQ32) begin
              v_q[2] <= v_q[2] - (v_q[3] - HiQ32); v_q[3] <= HiQ32;
            end
            5'd20: if (v_q[4] > HiQ32) begin
              v_q[5] <= v_q[5] - (v_q[4] - HiQ32); v_q[4] <= HiQ32;
            end
            5'd21: if (v_q[5] > HiQ32) begin
              v_q[4] <= v_q[4] - (v_q[5] - HiQ32); v_q[5] <= HiQ32;
            end
            default: ;
          endcase
          if (step_q == LastStep) state_q <= ST_DONE;
          else step_q <= step_q + 5'd1;
        end
        ST_DONE: begin
          // Load the result once the output register is free
          if (out_load) begin
            out_data_q <= armed_q ? mix_data : '0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("tready high while a tick is in progress");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= LastStep))
    else $error("sequencer step out of range");

  a_armed_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (state_q == ST_RUN))
    else $error("armed tick did not start the sequencer");

  a_disarmed_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> (state_q == ST_DONE))
    else $error("disarmed tick entered the sequencer");

endmodule

>>> test/hexacopter_attitude_pid_mixer_core_tb.sv
// ---------------------------------------------------------------------------
// hexacopter_attitude_pid_mixer_core_tb: self-checking bench for the PID mixer
// Drives sensor ticks on the input stream and predicts each set of six motor
// commands with a bit-exact fixed-point model kept in step with the block.
// Covers disarmed ticks, field extremes, integrator windup, gain and throttle
// extremes, random traffic with idling on both sides and long output stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module hexacopter_attitude_pid_mixer_core_tb;
  import hxpid_pkg::*;

  localparam int  CycleLimit = 800000;
  localparam int  DrainCycles = 30;
  localparam longint MotorHi = longint'(MotorMaxDefault) <<< 32;
  localparam longint MotorLo = longint'(MotorMinDefault) <<< 32;

  typedef struct packed {
    logic               armed;
    logic signed [15:0] accel_pitch;
    logic signed [15:0] accel_roll;
    logic signed [15:0] gyro_pitch;
    logic signed [15:0] gyro_roll;
    logic signed [11:0] pitch_ref;
    logic signed [11:0] roll_ref;
  } tick_t;

  typedef logic [5:0][10:0] motors_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [23:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  // Mirror of the gains and throttle
  logic [23:0] gain_pitch_p, gain_pitch_d, gain_pitch_i;
  logic [23:0] gain_roll_p, gain_roll_d, gain_roll_i;
  logic [10:0] throttle_base;

  // Mirror of the filter, error and integrator state
  logic signed [15:0] smp_pitch, smp_roll, smp_rate;
  logic signed [23:0] filt_pitch, filt_roll, filt_rate;
  logic signed [23:0] err_pitch, err_roll;
  logic signed [31:0] integ_pitch, integ_roll;

  motors_t motor_q[$];
  int      errors;
  int      ticks_sent;
  int      results_seen;
  int      cycles;
  int      burst_left;
  int      stall_hold;
  int      pat_mode;
  int      pat_left;
  string   motor_names[6] = '{"motor_one", "motor_two", "motor_three",
                              "motor_four", "motor_five", "motor_six"};
  int      opposite_motor[7] = '{0, 2, 1, 4, 3, 6, 5};

  hexacopter_attitude_pid_mixer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint round_shr(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat_to(longint x, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  // Advance the mirrored controller by one tick and queue its motor commands
  function automatic void step_controller(tick_t t);
    longint  pf, rf, gf, pe, re, r, p, r16, p16, thr, x;
    longint  v[7];
    motors_t res;
    res = '0;
    if (!t.armed) begin
      motor_q.push_back(res);
      return;
    end
    pf = sat_to(round_shr(longint'(filt_pitch) * 59297
                          + longint'(smp_pitch) * 6236 * 256, 16), 24);
    rf = sat_to(round_shr(longint'(filt_roll) * 59297
                          + longint'(smp_roll) * 6236 * 256, 16), 24);
    gf = sat_to(round_shr(longint'(filt_rate) * 166
                          + longint'(smp_rate) * 65372 * 256, 16), 24);
    integ_pitch = 32'(sat_to(longint'(integ_pitch) + longint'(err_pitch), 32));
    integ_roll  = 32'(sat_to(longint'(integ_roll) + longint'(err_roll), 32));
    pe = sat_to(longint'(t.pitch_ref) * 256 - pf, 24);
    re = sat_to(longint'(t.roll_ref) * 256 - rf, 24);
    r = longint'(gain_roll_p) * re - longint'(gain_roll_d) * gf
        + longint'(gain_roll_i) * longint'(integ_roll);
    p = longint'(gain_pitch_p) * pe + longint'(gain_pitch_d) * (longint'(t.gyro_pitch) * 256)
        + longint'(gain_pitch_i) * longint'(integ_pitch);
    r16 = round_shr(r, 14);
    p16 = round_shr(p, 14);
    thr = longint'(throttle_base) <<< 32;
    v[0] = 0;
    v[1] = thr + r16 * 65536;
    v[2] = thr - r16 * 65536;
    v[3] = thr - r16 * 32768 - p16 * 56754;
    v[4] = thr + r16 * 32768 + p16 * 56754;
    v[5] = thr + r16 * 32768 - p16 * 56754;
    v[6] = thr - r16 * 32768 + p16 * 56754;
    // Cap each motor in turn and push its excess onto the opposite one
    for (int k = 1; k <= 6; k++) begin
      if (v[k] > MotorHi) begin
        v[opposite_motor[k]] -= v[k] - MotorHi;
        v[k] = MotorHi;
      end
    end
    for (int k = 1; k <= 6; k++) begin
      x = v[k] < MotorLo ? MotorLo : (v[k] > MotorHi ? MotorHi : v[k]);
      x = round_shr(x, 32);
      if (x < 0) x = 0;
      if (x > 2047) x = 2047;
      res[k-1] = x[10:0];
    end
    smp_pitch  = t.accel_pitch;
    smp_roll   = t.accel_roll;
    smp_rate   = t.gyro_roll;
    filt_pitch = 24'(pf);
    filt_roll  = 24'(rf);
    filt_rate  = 24'(gf);
    err_pitch  = 24'(pe);
    err_roll   = 24'(re);
    motor_q.push_back(res);
  endfunction

  // Send one tick; keep tvalid high inside a burst, idle a random gap (possibly none) between bursts
  task automatic send_tick(tick_t t);
    int gap;
    s_axis_tdata  <= {t.roll_ref, t.pitch_ref, t.gyro_roll, t.gyro_pitch,
                      t.accel_roll, t.accel_pitch};
    s_axis_tuser  <= t.armed;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    step_controller(t);
    ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop tvalid and wait until every queued result has come back
  task automatic drain();
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (motor_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(reg_idx_e idx, logic [23:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PITCH_P:  gain_pitch_p = val;
      REG_PITCH_D:  gain_pitch_d = val;
      REG_PITCH_I:  gain_pitch_i = val;
      REG_ROLL_P:   gain_roll_p = val;
      REG_ROLL_D:   gain_roll_d = val;
      REG_ROLL_I:   gain_roll_i = val;
      REG_BASE_THR: throttle_base = val[10:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [23:0] pp, logic [23:0] pd, logic [23:0] pi,
                           logic [23:0] rp, logic [23:0] rd, logic [23:0] ri,
                           logic [10:0] thr);
    write_reg(REG_PITCH_P, pp);
    write_reg(REG_PITCH_D, pd);
    write_reg(REG_PITCH_I, pi);
    write_reg(REG_ROLL_P, rp);
    write_reg(REG_ROLL_D, rd);
    write_reg(REG_ROLL_I, ri);
    write_reg(REG_BASE_THR, {13'd0, thr});
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 4095) - 2048);
      2: return 16'($urandom_range(0, 255) - 128);
      default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic logic [11:0] rand_ref();
    if ($urandom_range(0, 4) == 0) return 12'($urandom);
    return 12'($urandom_range(0, 2048) - 1024);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.armed       = ($urandom_range(0, 9) != 0);
    t.accel_pitch = rand_sample();
    t.accel_roll  = rand_sample();
    t.gyro_pitch  = rand_sample();
    t.gyro_roll   = rand_sample();
    t.pitch_ref   = rand_ref();
    t.roll_ref    = rand_ref();
    return t;
  endfunction

  // Field extremes, bit patterns and the disarmed case
  task automatic test_directed();
    send_tick('{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF});
    send_tick('{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'h000, 12'h000});
    send_tick('{1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 12'd1024, 12'd1024});
    send_tick('{1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, -12'sd1024, -12'sd1024});
    send_tick('{1'b0, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, 12'h123, 12'h321});
    send_tick('{1'b1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 12'hAAA, 12'h555});
    send_tick('{1'b1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 12'h555, 12'hAAA});
    send_tick('{1'b1, 16'h7FFF, 16'h8000, 16'h0400, 16'hFC00, 12'h7FF, 12'h800});
    send_tick('{1'b1, 16'h8000, 16'h7FFF, 16'hFC00, 16'h0400, 12'h800, 12'h7FF});
    send_tick('{1'b1, 16'h0100, 16'hFF00, 16'h0010, 16'h0000, 12'h000, 12'h000});
    send_tick('{1'b1, 16'h0000, 16'h0000, 16'hFFF0, 16'h0000, 12'h000, 12'h000});
    send_tick('{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'h000, 12'h000});
    drain();
  endtask

  // Hold a large error long enough to drive the integrators into saturation
  task automatic test_windup(int n, logic signed [11:0] ref_val);
    tick_t t;
    for (int i = 0; i < n; i++) begin
      t = rand_tick();
      t.armed     = 1'b1;
      t.pitch_ref = ref_val;
      t.roll_ref  = -ref_val;
      t.accel_pitch = -16'sh7000;
      t.accel_roll  = 16'sh7000;
      send_tick(t);
    end
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_tick(rand_tick());
    drain();
  endtask

  // Hold the output off while ticks keep coming so the input stalls
  task automatic test_backpressure();
    stall_hold = 600;
    burst_left = 40;
    for (int i = 0; i < 20; i++) send_tick(rand_tick());
    drain();
  endtask

  // Receiver: long holds on request, otherwise its own stall pattern
  initial begin
    m_axis_tready = 1'b0;
    stall_hold = 0;
    pat_left = 0;
    pat_mode = 0;
    forever begin
      @(posedge clk_i);
      if (stall_hold > 0) begin
        m_axis_tready <= 1'b0;
        stall_hold--;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 2);
          pat_left = $urandom_range(20, 200);
        end
        pat_left--;
        case (pat_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) != 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    motors_t exp_m;
    motors_t got_m;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got_m = m_axis_tdata[65:0];
      if (motor_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        exp_m = motor_q.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (got_m[k] !== exp_m[k]) begin
            $error("%s: expected %0d, got %0d", motor_names[k], exp_m[k], got_m[k]);
            errors++;
          end
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("hexacopter_attitude_pid_mixer_core test failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    ticks_sent = 0;
    results_seen = 0;
    cycles = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_addr_i <= REG_PITCH_P;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    gain_pitch_p = PitchPRst;
    gain_pitch_d = PitchDRst;
    gain_pitch_i = PitchIRst;
    gain_roll_p = RollPRst;
    gain_roll_d = RollDRst;
    gain_roll_i = RollIRst;
    throttle_base = BaseThrRst;
    {smp_pitch, smp_roll, smp_rate} = '0;
    {filt_pitch, filt_roll, filt_rate, err_pitch, err_roll} = '0;
    {integ_pitch, integ_roll} = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_windup(300, 12'sh7FF);
    test_random(250);
    test_backpressure();
    write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 11'd0);
    test_random(120);
    write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              24'hFFFFFF, 11'd2047);
    test_random(120);
    test_windup(40, -12'sh800);
    write_all(24'($urandom_range(0, 409600)), 24'($urandom_range(0, 2000000)),
              24'($urandom_range(0, 4096)), 24'($urandom_range(0, 409600)),
              24'($urandom_range(0, 2000000)), 24'($urandom_range(0, 4096)), 11'd1000);
    test_random(250);
    write_all(24'd4096, 24'd8192, 24'd1, 24'd4096, 24'd8192, 24'd1, 11'd2000);
    test_random(200);
    write_all(PitchPRst, PitchDRst, PitchIRst, RollPRst, RollDRst, RollIRst,
              11'($urandom_range(1000, 2000)));
    test_random(200);
    test_backpressure();
    drain();

    $display("Sent %0d sensor ticks, checked %0d motor results over six gain settings,",
             ticks_sent, results_seen);
    $display("including windup, disarmed ticks and long output stalls.");
    if (errors == 0) begin
      $display("hexacopter_attitude_pid_mixer_core test passed");
    end else begin
      $display("hexacopter_attitude_pid_mixer_core test failed");
    end
    $finish;
  end

endmodule
